@@ rtl/lcn_pkg.sv @@
// Shared constants and codes for the linear congruential noise generator.
`default_nettype none
package lcn_pkg;

  localparam int SEED_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIGIT_W   = 8;

  localparam logic [63:0] DEFAULT_MUL = 64'd65539;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INCR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/lcn_if.sv @@
// Valid/ready channel interfaces for generator commands and generated values.
`default_nettype none
interface lcn_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [lcn_pkg::SEED_W-1:0] seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface lcn_out_if;
  logic                      valid;
  logic                      ready;
  logic [lcn_pkg::OUT_W-1:0] next_value;

  modport source (output valid, output next_value, input ready);
  modport sink   (input valid, input next_value, output ready);
endinterface
`default_nettype wire

@@ rtl/linear_congruential_noise.sv @@
// Linear congruential noise generator with a shared multiply and remainder datapath.
// A tick runs a digit-serial multiply-add (ST_MUL), a reduce step (ST_REDUCE), a bit-serial
// remainder (ST_DIV) and an emit step (ST_EMIT); a zero or power-of-two modulus skips ST_DIV.
// Commands are taken only in ST_IDLE: no tick starts until the last result is issued.
// A load sets the seed and emits nothing; an untaken result holds the next tick in ST_EMIT.
// Synchronous active-low reset: state 1, multiplier 65539, increment and modulus 0.
`default_nettype none
module linear_congruential_noise #(
  parameter int WORD_WIDTH = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  lcn_in_if.sink                               in_chan,
  lcn_out_if.source                            out_chan,
  input  wire                                  cfg_we,
  input  wire  [lcn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [WORD_WIDTH-1:0]                cfg_wdata
);

  localparam int DIGITS = (WORD_WIDTH + lcn_pkg::DIGIT_W - 1) / lcn_pkg::DIGIT_W;
  localparam int CNT_W  = $clog2(WORD_WIDTH);
  localparam int PROD_W = WORD_WIDTH + lcn_pkg::DIGIT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REDUCE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                     st_r;
  logic [WORD_WIDTH-1:0]      mul_r;
  logic [WORD_WIDTH-1:0]      inc_r;
  logic [WORD_WIDTH-1:0]      mod_r;
  logic [WORD_WIDTH-1:0]      seed_r;
  logic [WORD_WIDTH-1:0]      acc_r;
  logic [WORD_WIDTH-1:0]      mcand_r;
  logic [WORD_WIDTH-1:0]      mplier_r;
  logic [WORD_WIDTH-1:0]      rem_r;
  logic [WORD_WIDTH-1:0]      res_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       out_valid_r;
  logic [lcn_pkg::OUT_W-1:0]  out_data_r;

  logic [PROD_W-1:0]          prod;
  logic [WORD_WIDTH:0]        trial;
  logic [WORD_WIDTH-1:0]      rem_nxt;
  logic [WORD_WIDTH-1:0]      mod_m1;
  logic                       mod_pow2;
  logic                       in_xfer;
  logic                       emit_go;

  assign in_chan.ready       = (st_r == ST_IDLE);
  assign in_xfer             = in_chan.valid && in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.next_value = out_data_r;
  assign emit_go             = (st_r == ST_EMIT) && (!out_valid_r || out_chan.ready);

  assign prod     = PROD_W'(mcand_r) * PROD_W'(mplier_r[lcn_pkg::DIGIT_W-1:0]);
  assign trial    = {rem_r, acc_r[WORD_WIDTH-1]};
  assign rem_nxt  = (trial >= {1'b0, mod_r}) ? WORD_WIDTH'(trial - {1'b0, mod_r})
                                             : trial[WORD_WIDTH-1:0];
  assign mod_m1   = mod_r - WORD_WIDTH'(1);
  assign mod_pow2 = ((mod_r & mod_m1) == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r <= WORD_WIDTH'(lcn_pkg::DEFAULT_MUL);
      inc_r <= '0;
      mod_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcn_pkg::REG_MULT: mul_r <= cfg_wdata;
        lcn_pkg::REG_INCR: inc_r <= cfg_wdata;
        lcn_pkg::REG_MOD:  mod_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      seed_r      <= WORD_WIDTH'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_chan.kind == lcn_pkg::KIND_LOAD) begin
              seed_r <= WORD_WIDTH'(in_chan.seed_value);
            end else begin
              acc_r    <= inc_r;
              mcand_r  <= seed_r;
              mplier_r <= mul_r;
              cnt_r    <= CNT_W'(DIGITS - 1);
              st_r     <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          acc_r    <= acc_r + prod[WORD_WIDTH-1:0];
          mcand_r  <= mcand_r << lcn_pkg::DIGIT_W;
          mplier_r <= mplier_r >> lcn_pkg::DIGIT_W;
          cnt_r    <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            st_r <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (mod_r == '0) begin
            res_r <= acc_r;
            st_r  <= ST_EMIT;
          end else if (mod_pow2) begin
            res_r <= acc_r & mod_m1;
            st_r  <= ST_EMIT;
          end else begin
            rem_r <= '0;
            cnt_r <= CNT_W'(WORD_WIDTH - 1);
            st_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          acc_r <= acc_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            res_r <= rem_nxt;
            st_r  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_data_r <= lcn_pkg::OUT_W'(res_r);
            seed_r     <= res_r;
            st_r       <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/lcn_checker.sv @@
// Port-level assertions for the linear congruential noise generator, bound to the top level.
`default_nettype none
module lcn_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_kind,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [lcn_pkg::OUT_W-1:0]   out_next_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_value))
    else $error("result changed or dropped while stalled");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == lcn_pkg::KIND_TICK) |=> !in_ready)
    else $error("command taken while a step is in progress");

  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == lcn_pkg::KIND_LOAD) |=> in_ready && !$rose(out_valid))
    else $error("seed load produced a result or stalled the input");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued while the step is still busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind linear_congruential_noise lcn_checker u_lcn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_kind        (in_chan.kind),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_next_value (out_chan.next_value)
);
`default_nettype wire
